>>> rtl/binary_image_thinning_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thinning core
// Shared concurrent check wrappers, clocked on clk and held off by rst.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_THINNING_CORE_DEFINES_SVH
`define BINARY_IMAGE_THINNING_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define BITC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle forces consequent in the next
`define BITC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bitc_pkg.sv
// ----------------------------------------------------------------------------
// bitc_pkg
// Types, constants and the per-pixel deletion test of the thinning core.
// ----------------------------------------------------------------------------
package bitc_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int PIX_W    = 64;   // row word width on the ports
  localparam int ROWNUM_W = 6;
  localparam int PASS_W   = 13;
  localparam int CFG_W    = 7;

  localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(4096);
  localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(64);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_THIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic second;   // second subiteration end-point term
    logic row_ok;   // current row is an interior row
  } mark_ctl_t;

  // n = {n7..n0}: S, SW, W, NW, N, NE, E, SE in bits 0..7
  function automatic logic guo_hall_mark(input logic [7:0] n, input logic second);
    logic [2:0] conn;
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] m;
    logic       endp;
    conn = 3'(~n[0] & (n[1] | n[2])) + 3'(~n[2] & (n[3] | n[4]))
         + 3'(~n[4] & (n[5] | n[6])) + 3'(~n[6] & (n[7] | n[0]));
    a = 3'(n[0] | n[1]) + 3'(n[2] | n[3]) + 3'(n[4] | n[5]) + 3'(n[6] | n[7]);
    b = 3'(n[1] | n[2]) + 3'(n[3] | n[4]) + 3'(n[5] | n[6]) + 3'(n[7] | n[0]);
    m = (a < b) ? a : b;
    if (second) begin
      endp = n[4] & (n[5] | n[6] | ~n[3]);
    end else begin
      endp = n[0] & (n[1] | n[2] | ~n[7]);
    end
    return (conn == 3'd1) && (m >= 3'd2) && (m <= 3'd3) && !endp;
  endfunction

endpackage

>>> rtl/bitc_ifaces.sv
// ----------------------------------------------------------------------------
// bitc channel interfaces
// Valid/ready channels for input rows, thinned rows and the width register.
// ----------------------------------------------------------------------------
interface bitc_in_if import bitc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] row_pixels;
  logic             final_row;

  modport source (output valid, output row_pixels, output final_row, input ready);
  modport sink   (input valid, input row_pixels, input final_row, output ready);
endinterface

interface bitc_out_if import bitc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    thinned_row;
  logic [ROWNUM_W-1:0] row_number;
  logic                last_of_image;
  logic [PASS_W-1:0]   passes_taken;

  modport source (output valid, output thinned_row, output row_number,
                  output last_of_image, output passes_taken, input ready);
  modport sink   (input valid, input thinned_row, input row_number,
                  input last_of_image, input passes_taken, output ready);
endinterface

interface bitc_cfg_if import bitc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] columns_in_use;

  modport source (output valid, output columns_in_use, input ready);
  modport sink   (input valid, input columns_in_use, output ready);
endinterface

>>> rtl/bitc_row_mem.sv
// ----------------------------------------------------------------------------
// bitc_row_mem
// Image row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bitc_row_mem import bitc_pkg::*; #(
  parameter int WIDTH = DEF_MAX_COLUMNS,
  parameter int DEPTH = DEF_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bitc_mark_row.sv
// ----------------------------------------------------------------------------
// bitc_mark_row
// Deletion marks for one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module bitc_mark_row import bitc_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic [MAX_COLUMNS-1:0] up,
  input  logic [MAX_COLUMNS-1:0] mid,
  input  logic [MAX_COLUMNS-1:0] dn,
  input  logic [MAX_COLUMNS-1:0] int_mask,
  input  mark_ctl_t              ctl,
  output logic [MAX_COLUMNS-1:0] marks
);

  // _l: bit c holds column c-1, _r: bit c holds column c+1
  logic [MAX_COLUMNS-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;

  assign up_l  = {up[MAX_COLUMNS-2:0], 1'b0};
  assign mid_l = {mid[MAX_COLUMNS-2:0], 1'b0};
  assign dn_l  = {dn[MAX_COLUMNS-2:0], 1'b0};
  assign up_r  = {1'b0, up[MAX_COLUMNS-1:1]};
  assign mid_r = {1'b0, mid[MAX_COLUMNS-1:1]};
  assign dn_r  = {1'b0, dn[MAX_COLUMNS-1:1]};

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      marks[c] = ctl.row_ok & int_mask[c] & mid[c]
               & guo_hall_mark({dn_r[c], mid_r[c], up_r[c], up[c],
                                up_l[c], mid_l[c], dn_l[c], dn[c]}, ctl.second);
    end
  end

endmodule

>>> rtl/binary_image_thinning_core.sv
// ----------------------------------------------------------------------------
// binary_image_thinning_core
// Rows load at one per cycle. Thinning sweeps the H rows in passes of two
// subiterations, reading one row from the store per step and writing a row back
// only where it has marks, until a pass deletes nothing. Rows then leave via
// EMIT_RD and EMIT_LD, one at a time. rst clears control; the store is not cleared.
// ----------------------------------------------------------------------------
`include "binary_image_thinning_core_defines.svh"

module binary_image_thinning_core import bitc_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input logic       clk,
  input logic       rst,
  bitc_in_if.sink   pix_in,
  bitc_out_if.source pix_out,
  bitc_cfg_if.sink  cfg
);

  localparam int RA_W = $clog2(MAX_ROWS);       // row address
  localparam int RC_W = $clog2(MAX_ROWS + 1);   // row count
  localparam int ST_W = $clog2(MAX_ROWS + 2);   // sweep step, 0..H+1

  // --------------------------------------------------------------------------
  // Width register and column masks
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]       cfg_cols;
  logic [CFG_W-1:0]       act_w;
  logic [MAX_COLUMNS-1:0] col_mask;   // columns inside the image
  logic [MAX_COLUMNS-1:0] int_mask;   // columns 1..W-2, deletable

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      cfg_cols <= cfg.columns_in_use;
    end
  end

  // a width above the store width acts as the store width
  assign act_w = (cfg_cols > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cfg_cols;

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = CFG_W'(c) < act_w;
      int_mask[c] = (c != 0) && (CFG_W'(c + 1) < act_w);
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  state_t           state, state_next;
  logic [RC_W-1:0]  rows_loaded, rows_loaded_next;
  logic [RC_W-1:0]  img_rows, img_rows_next;
  logic [ST_W-1:0]  step, step_next;
  logic             second, second_next;
  logic             any_del, any_del_next;
  logic [PASS_W-1:0] pass_counter, pass_counter_next;
  logic [RA_W-1:0]  emit_ptr, emit_ptr_next;

  // row window of the sweep: rows r-1 and r before this subiteration's deletes
  logic [MAX_COLUMNS-1:0] w_prev, w_prev_next;
  logic [MAX_COLUMNS-1:0] w_cur, w_cur_next;

  // output word register
  logic                out_valid, out_valid_next;
  logic                out_load;
  logic [MAX_COLUMNS-1:0] out_row;
  logic [ROWNUM_W-1:0] out_num;
  logic                out_last;
  logic [PASS_W-1:0]   out_pass;

  // row store ports
  logic                   mem_we, mem_re;
  logic [RA_W-1:0]        wr_addr, rd_addr;
  logic [MAX_COLUMNS-1:0] wr_data, rd_q;

  // mark logic
  logic [MAX_COLUMNS-1:0] next_row, marks;
  mark_ctl_t              mctl;

  logic             in_acc, out_acc;
  logic [ST_W-1:0]  h_ext;
  logic [ST_W-1:0]  row_idx;   // row being marked, step-2
  logic             emit_last;

  assign in_acc  = pix_in.valid && pix_in.ready;
  assign out_acc = pix_out.valid && pix_out.ready;
  assign pix_in.ready = (state == ST_LOAD);

  assign h_ext   = ST_W'(img_rows);
  assign row_idx = step - ST_W'(2);

  // incoming row of the window: row step-1, or background past the bottom
  assign next_row = ((step != '0) && (step <= h_ext)) ? (rd_q & col_mask) : '0;

  // first and last rows stay; steps 0 and 1 only prime the window
  assign mctl.second = second;
  assign mctl.row_ok = (state == ST_THIN) && (step > ST_W'(2))
                     && (step != h_ext + ST_W'(1));

  assign emit_last = (RC_W'(emit_ptr) + RC_W'(1)) == img_rows;

  bitc_mark_row #(.MAX_COLUMNS(MAX_COLUMNS)) u_mark (
    .up       (w_prev),
    .mid      (w_cur),
    .dn       (next_row),
    .int_mask (int_mask),
    .ctl      (mctl),
    .marks    (marks)
  );

  bitc_row_mem #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  //   LOAD    : store each row (masked to width); final row starts thinning
  //   THIN    : sweep rows, read row s, mark row s-2, write it back cleared
  //   EMIT_RD : read row emit_ptr
  //   EMIT_LD : move it to the output word when that register is free
  // Write of row s-2 and read of row s never hit the same entry.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      rows_loaded  <= '0;
      pass_counter <= '0;
      any_del      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      rows_loaded  <= rows_loaded_next;
      pass_counter <= pass_counter_next;
      any_del      <= any_del_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    img_rows <= img_rows_next;
    step     <= step_next;
    second   <= second_next;
    emit_ptr <= emit_ptr_next;
    w_prev   <= w_prev_next;
    w_cur    <= w_cur_next;
    if (out_load) begin
      out_row  <= rd_q & col_mask;
      out_num  <= ROWNUM_W'(emit_ptr);
      out_last <= emit_last;
      out_pass <= pass_counter;
    end
  end

  always_comb begin
    state_next        = state;
    rows_loaded_next  = rows_loaded;
    img_rows_next     = img_rows;
    step_next         = step;
    second_next       = second;
    any_del_next      = any_del;
    pass_counter_next = pass_counter;
    emit_ptr_next     = emit_ptr;
    w_prev_next       = w_prev;
    w_cur_next        = w_cur;
    out_valid_next    = out_valid && !out_acc;
    out_load          = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    wr_addr           = rows_loaded[RA_W-1:0];
    wr_data           = pix_in.row_pixels[MAX_COLUMNS-1:0] & col_mask;
    rd_addr           = step[RA_W-1:0];

    case (state)
      ST_LOAD: begin
        if (in_acc) begin
          // a row past the store depth is dropped
          if (rows_loaded < RC_W'(MAX_ROWS)) begin
            mem_we           = 1'b1;
            rows_loaded_next = rows_loaded + RC_W'(1);
          end
          if (pix_in.final_row) begin
            img_rows_next     = rows_loaded_next;
            state_next        = ST_THIN;
            step_next         = '0;
            second_next       = 1'b0;
            any_del_next      = 1'b0;
            pass_counter_next = '0;
          end
        end
      end

      ST_THIN: begin
        mem_re  = step < h_ext;
        wr_addr = row_idx[RA_W-1:0];
        wr_data = w_cur & ~marks;
        mem_we  = marks != '0;
        if (marks != '0) begin
          any_del_next = 1'b1;
        end
        if (step == '0) begin
          w_prev_next = '0;
          w_cur_next  = '0;
        end else begin
          w_prev_next = w_cur;
          w_cur_next  = next_row;
        end
        if (step == h_ext + ST_W'(1)) begin
          step_next = '0;
          if (!second) begin
            second_next = 1'b1;
          end else begin
            // pair done: count it, go again only if it removed something
            if (pass_counter < PASS_LIMIT) begin
              pass_counter_next = pass_counter + PASS_W'(1);
            end
            second_next = 1'b0;
            if (any_del_next) begin
              any_del_next = 1'b0;
            end else begin
              state_next    = ST_EMIT_RD;
              emit_ptr_next = '0;
            end
          end
        end else begin
          step_next = step + ST_W'(1);
        end
      end

      ST_EMIT_RD: begin
        mem_re     = 1'b1;
        rd_addr    = emit_ptr;
        state_next = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (!out_valid || out_acc) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          if (emit_last) begin
            rows_loaded_next = '0;
            state_next       = ST_LOAD;
          end else begin
            emit_ptr_next = emit_ptr + RA_W'(1);
            state_next    = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output word
  // --------------------------------------------------------------------------
  assign pix_out.valid         = out_valid;
  assign pix_out.thinned_row   = PIX_W'(out_row);
  assign pix_out.row_number    = out_num;
  assign pix_out.last_of_image = out_last;
  assign pix_out.passes_taken  = out_pass;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `BITC_ASSERT(a_pass_sat, pass_counter <= PASS_LIMIT, "pass count past limit")
  `BITC_ASSERT_NEXT(a_final_starts, in_acc && pix_in.final_row, state == ST_THIN, "thin missed")
  `BITC_ASSERT(a_no_top_write, !(mem_we && (state == ST_THIN)) || (wr_addr != '0), "top row hit")
  `BITC_ASSERT_NEXT(a_out_hold, out_valid && !out_acc, out_valid && $stable(out_row), "word lost")

endmodule
